[design/qtpp_pkg.sv]
// Shared types and constants of the quadtree point partitioner.
// Used by every module of the block; depends on nothing.
package qtpp_pkg;

  localparam int NODES     = 1024;
  localparam int GRIDS     = 1024;
  localparam int SLOTS     = 64;
  localparam int MAX_DEPTH = 16;

  localparam int NODE_AW  = $clog2(NODES);
  localparam int GRID_AW  = $clog2(GRIDS);
  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
  localparam int CLR_N    = (NODES > GRIDS) ? NODES : GRIDS;
  localparam int CLR_W    = $clog2(CLR_N) + 1;
  localparam int LINK_W   = 10;
  localparam int COUNT_W  = 16;
  localparam int QDEPTH   = 2;
  localparam int QAW      = 1;

  localparam logic [1:0] MODE_NODE  = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_LEAF    = 2'd1;
  localparam logic [1:0] KIND_BRANCH  = 2'd2;

  localparam logic [1:0] REG_XBUF = 2'd0;
  localparam logic [1:0] REG_YBUF = 2'd1;
  localparam logic [1:0] REG_CAP  = 2'd2;

  typedef enum logic [1:0] {
    OP_NODE,
    OP_POINT,
    OP_CLEAR,
    OP_DROP
  } op_e;

  typedef struct packed {
    logic signed [31:0] split_x;
    logic signed [31:0] split_y;
    logic signed [31:0] bound_x;
    logic signed [31:0] bound_y;
    logic [4*LINK_W-1:0] children;
    logic [9:0]          grid;
  } node_t;

  typedef struct packed {
    op_e                op;
    logic               index_ok;
    logic [9:0]         node_index;
    logic [1:0]         kind;
    node_t              node;
    logic [9:0]         grid_index;
    logic [19:0]        pid;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

[design/qtpp_front.sv]
// Front end: accepts input beats, decodes the mode and range-checks indexes.
// Depends on qtpp_pkg; feeds qtpp_fifo.
module qtpp_front import qtpp_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         node_index_i,
  input  logic [1:0]         node_kind_i,
  input  logic signed [31:0] split_x_i,
  input  logic signed [31:0] split_y_i,
  input  logic signed [31:0] bound_x_i,
  input  logic signed [31:0] bound_y_i,
  input  logic [39:0]        child_links_i,
  input  logic [9:0]         grid_index_i,
  input  logic [19:0]        point_id_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  back_stat_t         stat_i,
  input  logic               full_i,
  output logic               push_o,
  output entry_t             push_data_o
);

  entry_t e;

  always_comb begin
    e = '0;
    unique case (mode_i)
      MODE_NODE:  e.op = OP_NODE;
      MODE_POINT: e.op = OP_POINT;
      MODE_CLEAR: e.op = OP_CLEAR;
      default:    e.op = OP_DROP;
    endcase
    e.node_index     = node_index_i;
    e.grid_index     = grid_index_i;
    e.index_ok       = (mode_i == MODE_NODE) ? (32'(node_index_i) < NODES)
                                             : (32'(grid_index_i) < GRIDS);
    e.kind           = (node_kind_i == KIND_LEAF || node_kind_i == KIND_BRANCH) ?
                       node_kind_i : KIND_INVALID;
    e.node.split_x   = split_x_i;
    e.node.split_y   = split_y_i;
    e.node.bound_x   = bound_x_i;
    e.node.bound_y   = bound_y_i;
    e.node.children  = child_links_i;
    e.node.grid      = grid_index_i;
    e.pid            = point_id_i;
    e.px             = point_x_i;
    e.py             = point_y_i;
  end

  assign in_ready_o  = !full_i && !stat_i.clearing;
  assign push_o      = in_valid_i && in_ready_o && (e.op != OP_DROP);
  assign push_data_o = e;

endmodule

[design/qtpp_fifo.sv]
// Two-entry queue between the front end and the back end.
// Depends on qtpp_pkg for the entry type.
module qtpp_fifo import qtpp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  entry_t         mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  assign full_o     = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

endmodule

[design/qtpp_back.sv]
// Back end: node table, bucket counts and slots, tree descent sequencer,
// output register. Depends on qtpp_pkg; drains qtpp_fifo.
module qtpp_back import qtpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      pop_data_i,
  output logic        pop_o,
  output back_stat_t  stat_o,
  input  logic [30:0] x_buffer_i,
  input  logic [30:0] y_buffer_i,
  input  logic [6:0]  capacity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] result_id_o,
  output logic [9:0]  result_grid_o,
  output logic [15:0] slot_o,
  output logic        stored_o,
  output logic        near_border_o,
  output logic        lost_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CNT  = 2'd2;

  logic [1:0] kind_mem [NODES];
  node_t      node_mem [NODES];
  logic [COUNT_W-1:0] cnt_mem [GRIDS];
  logic [19:0] slot_mem [GRIDS*SLOTS];

  logic [1:0]         rd_kind_q;
  node_t              rd_node_q;
  logic [COUNT_W-1:0] rd_cnt_q;

  logic [1:0]         state_q, state_d;
  logic               root_q, root_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [CLR_W-1:0]   clr_q;
  logic               clr_busy_q;
  logic               out_valid_q;
  logic [19:0]        pid_q;
  logic signed [31:0] px_q, py_q;
  logic [19:0]        res_id_q;
  logic [9:0]         res_grid_q;
  logic [15:0]        res_slot_q;
  logic               res_st_q, res_nb_q, res_lost_q;

  logic                kind_we, node_we, cnt_we, slot_we, node_re, cnt_re;
  logic [NODE_AW-1:0]  kind_wa, node_ra;
  logic [1:0]          kind_wd;
  logic [GRID_AW-1:0]  cnt_wa, cnt_ra;
  logic [COUNT_W-1:0]  cnt_wd;
  logic [GRID_AW+SLOT_AW-1:0] slot_wa;
  logic                out_free, out_load;
  logic                ld_lost, ld_st, ld_nb;
  logic [1:0]          cidx;
  logic [LINK_W-1:0]   nx;
  logic                grid_ok;
  logic signed [32:0]  sum_x, sum_y;

  always_ff @(posedge clk_i) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    if (node_we) node_mem[pop_data_i.node_index[NODE_AW-1:0]] <= pop_data_i.node;
    if (node_re) begin
      rd_kind_q <= kind_mem[node_ra];
      rd_node_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) rd_cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= pid_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case ({py_q > rd_node_q.split_y, px_q > rd_node_q.split_x})
      2'd0:    cidx = 2'd0;
      2'd1:    cidx = 2'd1;
      2'd2:    cidx = 2'd2;
      default: cidx = 2'd3;
    endcase
    unique case (cidx)
      2'd0:    nx = rd_node_q.children[LINK_W-1:0];
      2'd1:    nx = rd_node_q.children[2*LINK_W-1:LINK_W];
      2'd2:    nx = rd_node_q.children[3*LINK_W-1:2*LINK_W];
      default: nx = rd_node_q.children[4*LINK_W-1:3*LINK_W];
    endcase
  end

  assign grid_ok = (32'(rd_node_q.grid) < GRIDS);
  assign sum_x   = $signed({px_q[31], px_q}) + $signed({2'b00, x_buffer_i});
  assign sum_y   = $signed({py_q[31], py_q}) + $signed({2'b00, y_buffer_i});

  always_comb begin
    state_d = state_q;
    root_d  = root_q;
    depth_d = depth_q;
    pop_o   = 1'b0;
    kind_we = 1'b0;
    kind_wa = pop_data_i.node_index[NODE_AW-1:0];
    kind_wd = pop_data_i.kind;
    node_we = 1'b0;
    node_re = 1'b0;
    node_ra = '0;
    cnt_we  = 1'b0;
    cnt_wa  = pop_data_i.grid_index[GRID_AW-1:0];
    cnt_wd  = '0;
    cnt_re  = 1'b0;
    cnt_ra  = rd_node_q.grid[GRID_AW-1:0];
    slot_we = 1'b0;
    slot_wa = {rd_node_q.grid[GRID_AW-1:0], rd_cnt_q[SLOT_AW-1:0]};
    out_load = 1'b0;
    ld_lost = 1'b0;
    ld_st   = 1'b0;
    ld_nb   = 1'b0;
    if (clr_busy_q) begin
      kind_we = (32'(clr_q) < NODES);
      kind_wa = clr_q[NODE_AW-1:0];
      kind_wd = KIND_INVALID;
      cnt_we  = (32'(clr_q) < GRIDS);
      cnt_wa  = clr_q[GRID_AW-1:0];
      cnt_wd  = '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            pop_o = 1'b1;
            unique case (pop_data_i.op)
              OP_NODE: begin
                kind_we = pop_data_i.index_ok;
                node_we = pop_data_i.index_ok;
              end
              OP_CLEAR: begin
                cnt_we = pop_data_i.index_ok;
              end
              OP_POINT: begin
                node_re = 1'b1;
                root_d  = 1'b1;
                depth_d = '0;
                state_d = S_LOOK;
              end
              default: ;
            endcase
          end
        end
        S_LOOK: begin
          if (!root_q && rd_kind_q == KIND_LEAF) begin
            if (grid_ok) begin
              cnt_re  = 1'b1;
              state_d = S_CNT;
            end else if (out_free) begin
              out_load = 1'b1;
              ld_lost  = 1'b1;
              state_d  = S_IDLE;
            end
          end else if ((!root_q && rd_kind_q != KIND_BRANCH) ||
                       depth_q == DEPTH_W'(MAX_DEPTH) || 32'(nx) >= NODES) begin
            if (out_free) begin
              out_load = 1'b1;
              ld_lost  = 1'b1;
              state_d  = S_IDLE;
            end
          end else begin
            node_re = 1'b1;
            node_ra = nx[NODE_AW-1:0];
            root_d  = 1'b0;
            depth_d = depth_q + 1'b1;
          end
        end
        S_CNT: begin
          if (out_free) begin
            ld_st    = (rd_cnt_q < COUNT_W'(capacity_i)) && (32'(rd_cnt_q) < SLOTS);
            ld_nb    = (sum_x > $signed({rd_node_q.bound_x[31], rd_node_q.bound_x})) ||
                       (sum_y > $signed({rd_node_q.bound_y[31], rd_node_q.bound_y}));
            slot_we  = ld_st;
            cnt_we   = 1'b1;
            cnt_wa   = rd_node_q.grid[GRID_AW-1:0];
            cnt_wd   = (rd_cnt_q == '1) ? rd_cnt_q : rd_cnt_q + 1'b1;
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= 1'b0;
      depth_q     <= '0;
      clr_q       <= '0;
      clr_busy_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      depth_q <= depth_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_N - 1)) clr_busy_q <= 1'b0;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && pop_data_i.op == OP_POINT) begin
      pid_q <= pop_data_i.pid;
      px_q  <= pop_data_i.px;
      py_q  <= pop_data_i.py;
    end
    if (out_load) begin
      res_id_q   <= pid_q;
      res_grid_q <= ld_lost ? 10'd0 : rd_node_q.grid;
      res_slot_q <= ld_lost ? 16'd0 : rd_cnt_q;
      res_st_q   <= ld_st;
      res_nb_q   <= ld_nb;
      res_lost_q <= ld_lost;
    end
  end

  assign stat_o.clearing = clr_busy_q;
  assign out_valid_o     = out_valid_q;
  assign result_id_o     = res_id_q;
  assign result_grid_o   = res_grid_q;
  assign slot_o          = res_slot_q;
  assign stored_o        = res_st_q;
  assign near_border_o   = res_nb_q;
  assign lost_o          = res_lost_q;

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop_o) else $error("queue popped during clear pass");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_DEPTH)) else $error("descent depth overrun");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result overwritten");
  a_lost_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_lost_q |-> !res_st_q && !res_nb_q)
    else $error("lost result carries bucket data");

endmodule

[design/quadtree_point_partitioner.sv]
// Quadtree point partitioner. After reset a clear pass marks every node
// invalid and zeroes every bucket count; no beat is taken then. A node
// write or a count clear is done by the back end from its idle state. A
// point takes one node-table read per tree level plus a count
// read-modify-write. Config registers via APB at 0x0, 0x4, 0x8.
// Depends on qtpp_pkg, qtpp_front, qtpp_fifo, qtpp_back.
module quadtree_point_partitioner import qtpp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         node_index_i,
  input  logic [1:0]         node_kind_i,
  input  logic signed [31:0] split_x_i,
  input  logic signed [31:0] split_y_i,
  input  logic signed [31:0] bound_x_i,
  input  logic signed [31:0] bound_y_i,
  input  logic [39:0]        child_links_i,
  input  logic [9:0]         grid_index_i,
  input  logic [19:0]        point_id_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [19:0]        result_id_o,
  output logic [9:0]         result_grid_o,
  output logic [15:0]        slot_o,
  output logic               stored_o,
  output logic               near_border_o,
  output logic               lost_o
);

  logic [30:0] x_buffer_q, y_buffer_q;
  logic [6:0]  capacity_q;
  logic        wr;
  back_stat_t  stat;
  logic        push, full, pop, empty;
  entry_t      push_data, pop_data;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_buffer_q <= '0;
      y_buffer_q <= '0;
      capacity_q <= 7'd64;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_XBUF: x_buffer_q <= pwdata[30:0];
        REG_YBUF: y_buffer_q <= pwdata[30:0];
        REG_CAP:  capacity_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_XBUF: prdata = {1'b0, x_buffer_q};
      REG_YBUF: prdata = {1'b0, y_buffer_q};
      REG_CAP:  prdata = {25'd0, capacity_q};
      default:  prdata = '0;
    endcase
  end

  qtpp_front u_front (
    .in_valid_i, .in_ready_o, .mode_i, .node_index_i, .node_kind_i,
    .split_x_i, .split_y_i, .bound_x_i, .bound_y_i, .child_links_i,
    .grid_index_i, .point_id_i, .point_x_i, .point_y_i,
    .stat_i      (stat),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  qtpp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  qtpp_back u_back (
    .clk_i, .rst_ni,
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .stat_o     (stat),
    .x_buffer_i (x_buffer_q),
    .y_buffer_i (y_buffer_q),
    .capacity_i (capacity_q),
    .out_valid_o, .out_ready_i, .result_id_o, .result_grid_o, .slot_o,
    .stored_o, .near_border_o, .lost_o
  );

endmodule
